@@ design/tms_pkg.sv @@
// ----------------------------------------------------------------------------
// tms_pkg : shared types and constants for the two-mass RK4 step unit
// Holds the request and response structs, the default widths and the
// operation codes of the shared arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tms_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int OUT_WIDTH      = 32;
   localparam int CSR_WIDTH      = 31;
   localparam int DT_WIDTH       = 17;
   localparam int CSR_IDX_WIDTH  = 3;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPRING_K  = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DAMPING_C = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_INV_M1    = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_INV_M2    = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TIME_STEP = 3'd4;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] load_pos_one;
      logic signed [31:0] load_pos_two;
      logic signed [31:0] load_vel_one;
      logic signed [31:0] load_vel_two;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_one;
      logic signed [31:0] pos_two;
      logic signed [31:0] vel_one;
      logic signed [31:0] vel_two;
      logic               saturated;
   } rsp_type;

   // shared unit operations
   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_NEG  = 3'd2,
      OP_MUL  = 3'd3,
      OP_HALF = 3'd4,
      OP_MOV  = 3'd5
   } op_type;

endpackage
`default_nettype wire

@@ design/two_mass_spring_rk4_step_unit.sv @@
// ----------------------------------------------------------------------------
// two_mass_spring_rk4_step_unit : one RK4 step of a two-mass spring-damper
// Holds x1, x2, v1, v2 in signed fixed point and advances them by one
// saturating RK4 step per step request, or loads them on a load request.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  req     | in        | req_valid/stall  | tms_pkg::req_type
//  rsp     | out       | rsp_valid/stall  | tms_pkg::rsp_type
//  csr     | in        | csr_write_enable | index 3 bits, data 31 bits
//
//  A step request runs a microprogram of 116 operations on one shared
//  saturating add/sub/neg/halve/multiply unit, one a cycle: 4 copies, four
//  derivative passes of 14, three stage updates of 8 and 8 per state word
//  to combine. The COPY state then registers the result and rsp_valid
//  rises in the OUT state; a load goes from acceptance straight to COPY.
//  The request side is stalled from acceptance until the result is taken
//  and frees in the cycle after that. Synchronous active-high reset clears
//  the state, the registers to their defaults and the handshake; rsp stall
//  simply holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module two_mass_spring_rk4_step_unit #(
   parameter int DATA_WIDTH = tms_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = tms_pkg::FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire tms_pkg::req_type              req_payload,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output tms_pkg::rsp_type                   rsp_payload,
   input  wire logic                          csr_write_enable,
   input  wire logic [tms_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [tms_pkg::CSR_WIDTH-1:0] csr_write_data
);
   import tms_pkg::*;

   localparam int W = DATA_WIDTH;
   localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
   localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;
   localparam logic signed [W-1:0] SIXTH = W'((ONE_L + 64'd3) / 64'd6);
   localparam logic signed [W-1:0] ONE_FX = W'(ONE_L);
   localparam logic signed [W-1:0] DT_RESET = W'(655);

   // register file: 0..3 state, 4..7 scratch, 8..23 k-values, 24..27 temp,
   // 28..31 stage input; operand codes 32..37 pick the config registers
   // and SIXTH
   localparam int NREG = 32;
   localparam int AW = 5;
   localparam int RW = 6;
   localparam logic [RW-1:0] RX1 = 6'd0, RX2 = 6'd1, RV1 = 6'd2, RV2 = 6'd3;
   localparam logic [RW-1:0] RK = 6'd32, RC = 6'd33, RM1 = 6'd34, RM2 = 6'd35;
   localparam logic [RW-1:0] RDT = 6'd36;
   localparam logic [RW-1:0] RSX = 6'd37;
   localparam logic [RW-1:0] T0 = 6'd4, T1 = 6'd5, T2 = 6'd6, T3 = 6'd7;
   localparam logic [RW-1:0] T4 = 6'd24, T5 = 6'd25, T6 = 6'd26, T7 = 6'd27;
   localparam logic [RW-1:0] S0 = 6'd28; // stage input base, x1,x2,v1,v2
   localparam logic [AW-1:0] SV1 = 5'd30, SV2 = 5'd31; // stage velocities

   typedef struct packed {
      op_type          op;
      logic [RW-1:0]   a;
      logic [RW-1:0]   b;
      logic [RW-1:0]   d;
   } uop_type;

   localparam int PCW = 7;

   // build one micro-op from an operation, two operand codes and a destination
   function automatic uop_type mk(op_type o, int a, int b, int d);
      mk.op = o; mk.a = RW'(a); mk.b = RW'(b); mk.d = RW'(d);
   endfunction

   function automatic uop_type ucode(logic [PCW-1:0] pc);
      int p, seg, i, s, kb, lane;
      p = int'(pc);
      ucode = mk(OP_MOV, 0, 0, T0);
      if (p < 4) begin
         // copy state into stage input
         ucode = mk(OP_MOV, p, 0, int'(S0) + p);
      end else if (p < 4 + 4 * 14 + 3 * 8) begin
         i = p - 4;
         seg = 0;
         // each of 4 stages: 14 deriv uops, then (if not last) 8 stage uops
         for (int g = 0; g < 4; g++) begin
            if (i >= 22 * g) seg = g;
         end
         i = i - 22 * seg;
         s = int'(S0);
         kb = 8 + 4 * seg;
         if (i < 14) begin
            case (i)
               0:  ucode = mk(OP_SUB, s + 1, s, T0);          // delta
               1:  ucode = mk(OP_SUB, s + 3, s + 2, T1);      // dv
               2:  ucode = mk(OP_MUL, RK, T0, T2);            // kd
               3:  ucode = mk(OP_MUL, RC, T1, T3);            // cd
               4:  ucode = mk(OP_MUL, RK, s, T4);
               5:  ucode = mk(OP_NEG, T4, 0, T4);
               6:  ucode = mk(OP_MUL, RC, s + 2, T5);
               7:  ucode = mk(OP_SUB, T4, T5, T4);
               8:  ucode = mk(OP_ADD, T4, T2, T4);
               9:  ucode = mk(OP_ADD, T4, T3, T4);
               10: ucode = mk(OP_NEG, T2, 0, T6);
               11: ucode = mk(OP_SUB, T6, T3, T6);
               12: ucode = mk(OP_MUL, RM1, T4, kb + 2);
               default: ucode = mk(OP_MUL, RM2, T6, kb + 3);
            endcase
            // velocities become position derivatives; read s+2/s+3 directly
            if (i == 12 && seg == 0) ucode = mk(OP_MUL, RM1, T4, kb + 2);
         end else begin
            lane = (i - 14) >> 1;
            if (((i - 14) & 1) == 0) begin
               if (lane < 2) ucode = mk(OP_MUL, RDT, s + 2 + lane, T7);
               else ucode = mk(OP_MUL, RDT, kb + lane, T7);
               // tag: next op decides halving
            end else begin
               ucode = mk(seg == 2 ? OP_ADD : OP_HALF, lane, T7, s + lane);
            end
         end
      end else begin
         i = p - (4 + 4 * 14 + 3 * 8);
         ucode = mk(OP_MOV, 0, 0, T0);
         if (i < 1) ucode = mk(OP_MOV, 0, 0, T0);
      end
   endfunction

   // -------------------------------------------------------------------
   // The combine phase has its own decode: 8 uops per state word, the
   // last one writing the new value straight back into that word.
   // -------------------------------------------------------------------
   localparam int PC_COMB = 4 + 4 * 14 + 3 * 8; // 84
   localparam int NCOMB = 4 * 8;
   localparam int PC_END = PC_COMB + NCOMB;     // 116

   function automatic uop_type ucomb(int i);
      int lane, j, k1, k2, k3, k4;
      lane = i >> 3; j = i & 7;
      // position derivatives are the stage velocities, saved in k slots
      k1 = 8 + lane; k2 = 12 + lane; k3 = 16 + lane; k4 = 20 + lane;
      case (j)
         0: ucomb = mk(OP_ADD, k2, k2, T0);
         1: ucomb = mk(OP_ADD, k1, T0, T0);
         2: ucomb = mk(OP_ADD, k3, k3, T1);
         3: ucomb = mk(OP_ADD, T0, T1, T0);
         4: ucomb = mk(OP_ADD, T0, k4, T0);
         5: ucomb = mk(OP_MUL, RDT, T0, T0);
         6: ucomb = mk(OP_MUL, T0, RSX, T0);
         default: ucomb = mk(OP_ADD, lane, T0, lane);
      endcase
   endfunction

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RUN  = 4'b0010,
      ST_COPY = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [7:0] pc_ff, pc_in;
   logic signed [W-1:0] rf_ff [NREG];
   logic signed [W-1:0] k_ff, c_ff, m1_ff, m2_ff, dt_ff;
   logic sat_ff, sat_in;
   rsp_type rsp_ff, rsp_in;

   // micro-op decode
   uop_type uop;
   always_comb begin
      if (int'(pc_ff) >= PC_COMB) uop = ucomb(int'(pc_ff) - PC_COMB);
      else uop = ucode(pc_ff[PCW-1:0]);
   end

   // stage-velocity capture: position derivatives of stage g are the
   // stage input velocities; stored into k slots at the start of each deriv
   logic capture;
   logic [AW-1:0] cap_dst0;
   always_comb begin
      int i, g;
      i = int'(pc_ff) - 4;
      g = 0;
      for (int q = 0; q < 4; q++) if (i >= 22 * q) g = q;
      capture = (state_ff == ST_RUN) && (int'(pc_ff) >= 4) &&
                (int'(pc_ff) < PC_COMB) && (i - 22 * g == 0);
      cap_dst0 = AW'(8 + 4 * g);
   end

   // shared saturating unit
   logic signed [W-1:0] opa, opb, res;
   logic                res_sat;
   logic signed [2*W-1:0] prod;
   logic signed [2*W-1:0] pshift;
   logic signed [W:0]   wsum;
   always_comb begin
      case (uop.a)
         RK:      opa = k_ff;
         RC:      opa = c_ff;
         RM1:     opa = m1_ff;
         RM2:     opa = m2_ff;
         RDT:     opa = dt_ff;
         RSX:     opa = SIXTH;
         default: opa = rf_ff[uop.a[AW-1:0]];
      endcase
      case (uop.b)
         RK:      opb = k_ff;
         RC:      opb = c_ff;
         RM1:     opb = m1_ff;
         RM2:     opb = m2_ff;
         RDT:     opb = dt_ff;
         RSX:     opb = SIXTH;
         default: opb = rf_ff[uop.b[AW-1:0]];
      endcase
      prod = (2*W)'(opa) * (2*W)'(opb);
      pshift = prod >>> FRAC_BITS;
      res = opa;
      res_sat = 1'b0;
      wsum = '0;
      case (uop.op)
         OP_ADD, OP_HALF: begin
            if (uop.op == OP_HALF) wsum = {opa[W-1], opa} + (W+1)'(opb >>> 1);
            else wsum = {opa[W-1], opa} + {opb[W-1], opb};
         end
         OP_SUB: wsum = {opa[W-1], opa} - {opb[W-1], opb};
         OP_NEG: wsum = -{opa[W-1], opa};
         default: wsum = '0;
      endcase
      case (uop.op)
         OP_ADD, OP_HALF, OP_SUB, OP_NEG: begin
            if (wsum[W] != wsum[W-1]) begin
               res_sat = 1'b1;
               res = wsum[W] ? VMIN : VMAX;
            end else res = wsum[W-1:0];
         end
         OP_MUL: begin
            if (pshift > (2*W)'(VMAX)) begin
               res_sat = 1'b1; res = VMAX;
            end else if (pshift < (2*W)'(VMIN)) begin
               res_sat = 1'b1; res = VMIN;
            end else res = pshift[W-1:0];
         end
         default: res = opa;
      endcase
   end

   function automatic logic signed [W-1:0] cfgv(logic [CSR_WIDTH-1:0] v,
                                                 logic [CSR_WIDTH-1:0] m);
      logic [63:0] u;
      u = 64'(v & m);
      if (u > 64'(VMAX)) cfgv = VMAX;
      else cfgv = W'(u);
   endfunction

   function automatic logic signed [OUT_WIDTH-1:0] emitv(logic signed [W-1:0] v,
                                                         output logic s);
      s = 1'b0;
      if (64'(signed'(v)) > 64'sd2147483647) begin
         s = 1'b1; emitv = 32'sh7fffffff;
      end else if (64'(signed'(v)) < -64'sd2147483648) begin
         s = 1'b1; emitv = 32'sh80000000;
      end else emitv = OUT_WIDTH'(v);
   endfunction

   function automatic logic signed [W-1:0] loadv(logic signed [31:0] v,
                                                 output logic s);
      s = 1'b0;
      if (64'(v) > 64'(VMAX)) begin s = 1'b1; loadv = VMAX; end
      else if (64'(v) < 64'(signed'(VMIN))) begin s = 1'b1; loadv = VMIN; end
      else loadv = W'(v);
   endfunction

   // load values, clamped to the format
   logic signed [W-1:0] ld_x1, ld_x2, ld_v1, ld_v2;
   logic                ld_s0, ld_s1, ld_s2, ld_s3;
   always_comb begin
      ld_x1 = loadv(req_payload.load_pos_one, ld_s0);
      ld_x2 = loadv(req_payload.load_pos_two, ld_s1);
      ld_v1 = loadv(req_payload.load_vel_one, ld_s2);
      ld_v2 = loadv(req_payload.load_vel_two, ld_s3);
   end

   logic accept;
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_payload = rsp_ff;

   always_comb begin
      logic s0, s1, s2, s3;
      state_in = state_ff;
      pc_in = pc_ff;
      sat_in = sat_ff;
      rsp_in = rsp_ff;
      s0 = 1'b0; s1 = 1'b0; s2 = 1'b0; s3 = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pc_in = '0;
               sat_in = 1'b0;
               state_in = req_payload.kind ? ST_COPY : ST_RUN;
               if (req_payload.kind) sat_in = ld_s0 | ld_s1 | ld_s2 | ld_s3;
            end
         end
         ST_RUN: begin
            if (uop.op != OP_MOV) sat_in = sat_ff | res_sat;
            if (int'(pc_ff) == PC_END - 1) state_in = ST_COPY;
            pc_in = pc_ff + 8'd1;
         end
         ST_COPY: begin
            rsp_in.pos_one = emitv(rf_ff[RX1[AW-1:0]], s0);
            rsp_in.pos_two = emitv(rf_ff[RX2[AW-1:0]], s1);
            rsp_in.vel_one = emitv(rf_ff[RV1[AW-1:0]], s2);
            rsp_in.vel_two = emitv(rf_ff[RV2[AW-1:0]], s3);
            rsp_in.saturated = sat_ff | s0 | s1 | s2 | s3;
            state_in = ST_OUT;
         end
         ST_OUT: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff <= '0;
         sat_ff <= 1'b0;
         for (int r = 0; r < NREG; r++) rf_ff[r] <= '0;
         k_ff  <= (ONE_L > 64'(VMAX)) ? VMAX : ONE_FX;
         c_ff  <= '0;
         m1_ff <= (ONE_L > 64'(VMAX)) ? VMAX : ONE_FX;
         m2_ff <= (ONE_L > 64'(VMAX)) ? VMAX : ONE_FX;
         dt_ff <= DT_RESET;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         sat_ff <= sat_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SPRING_K:  k_ff  <= cfgv(csr_write_data, '1);
               CSR_DAMPING_C: c_ff  <= cfgv(csr_write_data, '1);
               CSR_INV_M1:    m1_ff <= cfgv(csr_write_data, '1);
               CSR_INV_M2:    m2_ff <= cfgv(csr_write_data, '1);
               CSR_TIME_STEP: dt_ff <= cfgv(csr_write_data,
                                            CSR_WIDTH'(18'h1ffff));
               default: ;
            endcase
         end
         if (state_ff == ST_IDLE && accept && req_payload.kind) begin
            rf_ff[RX1[AW-1:0]] <= ld_x1;
            rf_ff[RX2[AW-1:0]] <= ld_x2;
            rf_ff[RV1[AW-1:0]] <= ld_v1;
            rf_ff[RV2[AW-1:0]] <= ld_v2;
         end
         if (state_ff == ST_RUN) begin
            if (capture) begin
               rf_ff[cap_dst0]         <= rf_ff[SV1];
               rf_ff[cap_dst0 + 5'd1]  <= rf_ff[SV2];
            end
            if (uop.op != OP_MOV || int'(pc_ff) < 4) rf_ff[uop.d[AW-1:0]] <= res;
         end
         if (state_ff == ST_COPY) rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire

@@ design/tms_checker.sv @@
// ----------------------------------------------------------------------------
// tms_checker : port-level checks for the two-mass RK4 step unit
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tms_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire tms_pkg::rsp_type rsp_payload
);
   // one request in flight: no request taken while a result waits
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken during response");

   // a request taken always stalls the next cycle
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall) else $error("no stall after request");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("response dropped");

   // after a delivered result the unit is ready again
   a_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> (!rsp_valid && !req_stall))
      else $error("not ready after response");
endmodule

bind two_mass_spring_rk4_step_unit tms_checker u_tms_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
);
`default_nettype wire
